[rtl/prl_pkg.sv]
// Shared types and constants for the positional ring list.
package prl_pkg;

	localparam int OP_W       = 2;
	localparam int POS_W      = 7;
	localparam int VAL_W      = 32;
	localparam int ST_W       = 2;
	localparam int LEN_W      = 7;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_PAD_W  = OUT_DATA_W - VAL_W - ST_W - LEN_W;
	localparam int IN_PAD_W   = IN_DATA_W - POS_W - VAL_W;

	typedef enum logic [OP_W-1:0] {
		OP_GET    = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PREP,
		S_SHIFT,
		S_PUTV,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] value_out;
		status_t          status;
		logic [LEN_W-1:0] length;
	} res_t;

endpackage

[rtl/positional_ring_list_core.sv]
// Top level of the positional ring list: stream ports, result register and the store.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a circular store
// and serves one get, insert or delete at a 1-based position per input beat, each
// answered by one output beat carrying the value read or removed, a status and the
// new length. An insert or delete moves the shorter side of the list one element
// per cycle through the one read port and the one write port of the store. The
// input is not ready while a request is in progress; a new request is taken while
// the previous result is still waiting on the output.
// The store needs no clearing after reset.
module positional_ring_list_core #(
	parameter int CAPACITY = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// position, value_in
	input  logic [prl_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic [prl_pkg::OP_W-1:0]       s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// value_out, status, length
	output logic [prl_pkg::OUT_DATA_W-1:0] m_tdata
);

	import prl_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	req_t               req;
	res_t               res;
	logic               idle, start, res_valid, res_ready;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [VAL_W-1:0]   mem_wdata, mem_rdata;
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign req.op       = op_t'(s_tuser);
	assign req.position = s_tdata[POS_W-1:0];
	assign req.value_in = s_tdata[POS_W +: VAL_W];

	assign s_tready  = idle;
	assign start     = s_tvalid && idle;
	assign res_ready = !m_tvalid_q || m_tready;

	prl_ctrl #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.idle     (idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	prl_store #(
		.DEPTH(CAPACITY),
		.WIDTH(VAL_W),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, res.length, res.status, res.value_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/prl_store.sv]
// Element store: one write port and one read port with registered read data.
module prl_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/prl_ctrl.sv]
// Request sequencer: range checks, slot address unit and the one-element-a-cycle shifter.
module prl_ctrl #(
	parameter int CAPACITY = 64,
	parameter int AW       = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  prl_pkg::req_t             req,
	output logic                      idle,
	output logic                      res_valid,
	input  logic                      res_ready,
	output prl_pkg::res_t             res,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [prl_pkg::VAL_W-1:0] mem_wdata,
	output logic [AW-1:0]             mem_raddr,
	input  logic [prl_pkg::VAL_W-1:0] mem_rdata
);

	import prl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
	localparam logic [AW:0]   CAP_E = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	function automatic logic [AW-1:0] wrap_step(input logic [AW-1:0] a, input logic up);
		if (up) begin
			return (a == LAST) ? '0 : a + 1'b1;
		end else begin
			return (a == '0) ? LAST : a - 1'b1;
		end
	endfunction

	state_t        state_q, state_d;
	req_t          req_q, req_d;
	res_t          res_q, res_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] prev_q, prev_d;
	logic [CW-1:0] moves_q, moves_d;
	logic          up_q, up_d;
	logic          hside_q, hside_d;
	logic          wr_pend_s1, wpend_d;
	logic [AW-1:0] wr_addr_s1, waddr_d;

	logic [EW-1:0] pos_e, cnt_e, k_e;
	logic          get_del_ok, ins_ok, is_full, tail_side, pos_one, ins_head;
	logic [AW:0]   slot_sum, slot_red;
	logic [AW-1:0] slot_b;

	assign pos_e      = EW'(req_q.position);
	assign cnt_e      = EW'(count_q);
	assign get_del_ok = (pos_e != '0) && (pos_e <= cnt_e);
	assign ins_ok     = (pos_e != '0) && (pos_e <= cnt_e + EW'(1));
	assign is_full    = (count_q == CAP_C);
	assign tail_side  = pos_e > (cnt_e >> 1);
	assign pos_one    = (pos_e == EW'(1));
	assign ins_head   = pos_one || !tail_side;

	always_comb begin
		case (req_q.op)
			OP_INSERT: k_e = ins_head ? '0 : cnt_e - EW'(1);
			default:   k_e = pos_e - EW'(1);
		endcase
	end

	assign slot_sum = {1'b0, head_q} + {1'b0, k_e[AW-1:0]};
	assign slot_red = slot_sum - CAP_E;
	assign slot_b   = (slot_sum >= CAP_E) ? slot_red[AW-1:0] : slot_sum[AW-1:0];

	always_comb begin
		state_d   = state_q;
		req_d     = req_q;
		res_d     = res_q;
		head_d    = head_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		prev_d    = prev_q;
		moves_d   = moves_q;
		up_d      = up_q;
		hside_d   = hside_q;
		wpend_d   = 1'b0;
		waddr_d   = wr_addr_s1;
		idle      = 1'b0;
		res_valid = 1'b0;
		mem_raddr = ptr_q;
		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					req_d   = req;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				mem_raddr       = slot_b;
				ptr_d           = slot_b;
				res_d.value_out = '0;
				res_d.status    = ST_BAD_INDEX;
				res_d.length    = LEN_W'(count_q);
				state_d         = S_DONE;
				case (req_q.op)
					OP_GET: begin
						if (get_del_ok) begin
							state_d = S_PREP;
						end
					end
					OP_DELETE: begin
						if (get_del_ok) begin
							state_d = S_PREP;
							hside_d = !tail_side;
							up_d    = tail_side;
							moves_d = tail_side ? CW'(cnt_e - pos_e) : CW'(pos_e - EW'(1));
						end
					end
					OP_INSERT: begin
						if (ins_ok) begin
							if (is_full) begin
								res_d.status = ST_FULL;
							end else begin
								state_d = S_PREP;
								hside_d = ins_head;
								up_d    = ins_head;
								moves_d = ins_head ? CW'(pos_e - EW'(1))
								                   : CW'(cnt_e - pos_e + EW'(1));
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_PREP: begin
				res_d.status = ST_OK;
				case (req_q.op)
					OP_GET: begin
						res_d.value_out = mem_rdata;
						res_d.length    = LEN_W'(count_q);
						state_d         = S_DONE;
					end
					OP_DELETE: begin
						res_d.value_out = mem_rdata;
						count_d         = count_q - 1'b1;
						res_d.length    = LEN_W'(count_q - 1'b1);
						prev_d          = ptr_q;
						ptr_d           = wrap_step(ptr_q, up_q);
						if (hside_q) begin
							head_d = wrap_step(head_q, 1'b1);
						end
						state_d = S_SHIFT;
					end
					default: begin
						res_d.value_out = '0;
						count_d         = count_q + 1'b1;
						res_d.length    = LEN_W'(count_q + 1'b1);
						prev_d          = wrap_step(ptr_q, !up_q);
						if (hside_q) begin
							head_d = wrap_step(head_q, 1'b0);
						end
						state_d = S_SHIFT;
					end
				endcase
			end
			S_SHIFT: begin
				if (moves_q != '0) begin
					wpend_d = 1'b1;
					waddr_d = prev_q;
					prev_d  = ptr_q;
					ptr_d   = wrap_step(ptr_q, up_q);
					moves_d = moves_q - 1'b1;
				end else begin
					state_d = (req_q.op == OP_INSERT) ? S_PUTV : S_DONE;
				end
			end
			S_PUTV: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			count_q    <= count_d;
			wr_pend_s1 <= wpend_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q      <= req_d;
		res_q      <= res_d;
		ptr_q      <= ptr_d;
		prev_q     <= prev_d;
		moves_q    <= moves_d;
		up_q       <= up_d;
		hside_q    <= hside_d;
		wr_addr_s1 <= waddr_d;
	end

	assign mem_we    = wr_pend_s1 || (state_q == S_PUTV);
	assign mem_waddr = wr_pend_s1 ? wr_addr_s1 : prev_q;
	assign mem_wdata = wr_pend_s1 ? mem_rdata : req_q.value_in;
	assign res       = res_q;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the positional ring list core.
`timescale 1ns / 100ps

module testbench;
	import prl_pkg::*;

	localparam int CAPACITY = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 45;
	localparam int PHASE_ITEMS = 100;
	localparam int PHASE_COUNT = 15;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int PH_GROW = 0;
	localparam int PH_SHRINK = 1;
	localparam int PH_MIXED = 2;

	class list_scoreboard;
		logic [VAL_W-1:0] contents[$];
		res_t pending[$];
		int failures = 0;

		function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val);
			res_t r;
			int p;
			int n;
			p = pos;
			n = contents.size();
			r.value_out = '0;
			r.status = ST_BAD_INDEX;
			case (op)
				OP_GET: begin
					if (p >= 1 && p <= n) begin
						r.value_out = contents[p-1];
						r.status = ST_OK;
					end
				end
				OP_INSERT: begin
					if (p >= 1 && p <= n + 1) begin
						if (n >= CAPACITY) begin
							r.status = ST_FULL;
						end else begin
							contents.insert(p - 1, val);
							r.status = ST_OK;
						end
					end
				end
				OP_DELETE: begin
					if (p >= 1 && p <= n) begin
						r.value_out = contents[p-1];
						contents.delete(p - 1);
						r.status = ST_OK;
					end
				end
				default: begin
				end
			endcase
			r.length = LEN_W'(contents.size());
			pending.push_back(r);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] d);
			res_t e;
			logic [VAL_W-1:0] got_value;
			logic [ST_W-1:0] got_status;
			logic [LEN_W-1:0] got_length;
			got_value = d[VAL_W-1:0];
			got_status = d[VAL_W +: ST_W];
			got_length = d[VAL_W+ST_W +: LEN_W];
			if (pending.size() == 0) begin
				$error("Result beat with no request outstanding: data %h", d);
				failures++;
				return;
			end
			e = pending.pop_front();
			if (got_value !== e.value_out) begin
				$error("value_out mismatch: expected %0d, actual %0d",
					$signed(e.value_out), $signed(got_value));
				failures++;
			end
			if (got_status !== e.status) begin
				$error("status mismatch: expected %0d, actual %0d", e.status, got_status);
				failures++;
			end
			if (got_length !== e.length) begin
				$error("length mismatch: expected %0d, actual %0d", e.length, got_length);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [OP_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	list_scoreboard sb = new();
	bit send_steady = 0;
	bit take_steady = 0;
	int cycles = 0;

	positional_ring_list_core #(.CAPACITY(CAPACITY)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser <= op;
		s_tdata <= {{IN_PAD_W{1'b0}}, val, pos};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, pos, val);
	endtask

	task automatic random_request(input int kind);
		int size;
		int roll;
		int hi;
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		size = sb.contents.size();
		roll = $urandom_range(0, 99);
		case (kind)
			PH_GROW: op = roll < 70 ? OP_INSERT : (roll < 85 ? OP_DELETE : OP_GET);
			PH_SHRINK: op = roll < 65 ? OP_DELETE : (roll < 80 ? OP_INSERT : OP_GET);
			default: op = roll < 35 ? OP_INSERT : (roll < 70 ? OP_DELETE : OP_GET);
		endcase
		hi = (op == OP_INSERT) ? size + 1 : size;
		if ($urandom_range(0, 9) == 0 || hi == 0) begin
			pos = POS_W'($urandom_range(0, 65));
			if ($urandom_range(0, 3) == 0)
				op = OP_UNUSED;
		end else begin
			case ($urandom_range(0, 3))
				0: pos = POS_W'(1);
				1: pos = POS_W'(hi);
				default: pos = POS_W'($urandom_range(1, hi));
			endcase
		end
		case ($urandom_range(0, 7))
			0: val = 32'h7FFF_FFFF;
			1: val = 32'h8000_0000;
			2: val = 32'h0000_0000;
			3: val = 32'hFFFF_FFFF;
			default: val = $urandom;
		endcase
		send_request(op, pos, val);
	endtask

	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			gap = take_steady ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			m_tready <= (gap == 0);
			if (gap > 0) begin
				repeat (gap) @(negedge clk);
				m_tready <= 1'b1;
			end
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(OP_GET, 1, 32'h0);
		send_request(OP_DELETE, 1, 32'h0);
		send_request(OP_INSERT, 0, 32'h1234_5678);
		send_request(OP_INSERT, 2, 32'h1234_5678);
		send_request(OP_INSERT, 1, 32'h7FFF_FFFF);
		send_request(OP_INSERT, 2, 32'h8000_0000);
		send_request(OP_INSERT, 1, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 2, 32'h0000_0000);
		send_request(OP_INSERT, 2, 32'h5555_5555);
		send_request(OP_INSERT, 3, 32'hAAAA_AAAA);
		send_request(OP_GET, 0, 32'h0);
		send_request(OP_GET, 7, 32'h0);
		send_request(OP_GET, 3, 32'hFFFF_FFFF);
		send_request(OP_GET, 6, 32'h0);
		send_request(OP_UNUSED, 1, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 65, 32'h0000_0001);
		send_request(OP_DELETE, 2, 32'h0);
		send_request(OP_DELETE, 4, 32'h0);
		send_request(OP_DELETE, 4, 32'h0);
		send_request(OP_DELETE, 1, 32'h0);
		send_request(OP_DELETE, 0, 32'h0);
		send_request(OP_GET, 1, 32'h0);
		send_request(OP_GET, 2, 32'h0);

		// Start by filling the list so that refused inserts turn up early.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			int kind;
			kind = (ph == 0) ? PH_GROW : $urandom_range(0, 2);
			send_steady = ($urandom_range(0, 2) == 0);
			take_steady = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				random_request(kind);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
rtl/prl_pkg.sv
rtl/prl_store.sv
rtl/prl_ctrl.sv
rtl/positional_ring_list_core.sv
verif/testbench.sv
